[design/png_scanline_unfilter_core_defines.svh]
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core_defines
// Assertion macros used by the checker file of the scanline unfilter core.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psu checker: implication failed");

// next-cycle implication, disabled while reset is low
`define PSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psu checker: next-cycle check failed");

`endif

[design/psu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Types, limits and codes shared by the scanline unfilter modules.
// ----------------------------------------------------------------------------
package psu_pkg;

    // design limits
    localparam int MAX_ROW_BYTES       = 8192;
    localparam int MAX_BYTES_PER_PIXEL = 8;
    localparam int MAX_ROWS            = 8192;

    // field and register widths
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int BPP_W       = 4;
    localparam int BYTE_W      = 8;

    // derived widths
    localparam int POS_W     = $clog2(MAX_ROW_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_ROW_BYTES);
    localparam int ROWPOS_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int BPP_SEL_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BPP       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 2'd2;

    // filter type codes
    localparam logic [2:0] FILTER_NONE  = 3'd0;
    localparam logic [2:0] FILTER_SUB   = 3'd1;
    localparam logic [2:0] FILTER_UP    = 3'd2;
    localparam logic [2:0] FILTER_AVG   = 3'd3;
    localparam logic [2:0] FILTER_PAETH = 3'd4;

    // kind of work handed from front to back
    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_ERROR = 1'b1
    } op_kind_t;

    // one classified word between front and back
    typedef struct packed {
        op_kind_t             kind;
        logic [BYTE_W-1:0]    raw;
        logic [IDX_W-1:0]     index;
        logic [2:0]           filter;
        logic [BPP_SEL_W-1:0] bpp_sel;
        logic                 left_ok;
        logic                 first_row;
        logic                 row_end;
        logic                 image_end;
    } op_t;

    localparam int QUEUE_DEPTH = 4;

endpackage

[design/psu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_front
// Holds the configuration, tracks byte and row position, latches the filter
// type and the error state, and turns accepted data bytes and invalid type bytes into ops outside the error state.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_raw,
    // to queue
    input  logic                   q_full,
    output logic                   q_push,
    output op_t                    q_op
);

    logic [CFG_DATA_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]      bpp_reg;
    logic [CFG_DATA_W-1:0] row_count_reg;

    logic [POS_W-1:0]    pos_reg,        pos_next;
    logic [ROWPOS_W-1:0] row_pos_reg,    row_pos_next;
    logic [2:0]          filter_reg,     filter_next;
    logic                first_row_reg,  first_row_next;
    logic                err_reg,        err_next;

    logic [POS_W-1:0]  len_eff;
    logic [BPP_W-1:0]  bpp_eff;
    logic [CFG_DATA_W-1:0] rows_eff;
    logic              accept;
    logic              last_in_row;
    logic              last_in_image;
    logic              emit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // register clamping: zero counts as one, large values saturate
    always_comb begin
        if (row_bytes_reg == '0) begin
            len_eff = POS_W'(1);
        end else if (32'(row_bytes_reg) > MAX_ROW_BYTES) begin
            len_eff = POS_W'(MAX_ROW_BYTES);
        end else begin
            len_eff = POS_W'(row_bytes_reg);
        end
        if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (32'(bpp_reg) > MAX_BYTES_PER_PIXEL) begin
            bpp_eff = BPP_W'(MAX_BYTES_PER_PIXEL);
        end else begin
            bpp_eff = bpp_reg;
        end
        if (row_count_reg == '0) begin
            rows_eff = CFG_DATA_W'(1);
        end else if (32'(row_count_reg) > MAX_ROWS) begin
            rows_eff = CFG_DATA_W'(MAX_ROWS);
        end else begin
            rows_eff = row_count_reg;
        end
    end

    // row and image boundaries for the current data word
    assign last_in_row   = (pos_reg != '0) && (pos_reg >= len_eff);
    assign last_in_image = last_in_row && ((32'(row_pos_reg) + 32'd1) >= 32'(rows_eff));

    // classify the word and build the op
    always_comb begin
        emit          = 1'b0;
        q_op.kind     = OP_DATA;
        q_op.raw      = s_raw;
        q_op.index    = IDX_W'(pos_reg - POS_W'(1));
        q_op.filter   = filter_reg;
        q_op.bpp_sel  = BPP_SEL_W'(bpp_eff - BPP_W'(1));
        q_op.left_ok  = (32'(pos_reg) - 32'd1) >= 32'(bpp_eff);
        q_op.first_row = first_row_reg;
        q_op.row_end   = last_in_row;
        q_op.image_end = last_in_image;
        if (pos_reg == '0) begin
            if (!err_reg && (s_raw > BYTE_W'(FILTER_PAETH))) begin
                emit           = 1'b1;
                q_op.kind      = OP_ERROR;
                q_op.row_end   = 1'b0;
                q_op.image_end = 1'b0;
            end
        end else begin
            emit = !err_reg;
        end
    end

    assign q_push = accept && emit;

    // position, filter and error tracking
    always_comb begin
        pos_next       = pos_reg;
        row_pos_next   = row_pos_reg;
        filter_next    = filter_reg;
        first_row_next = first_row_reg;
        err_next       = err_reg;
        if (accept) begin
            if (pos_reg == '0) begin
                pos_next = POS_W'(1);
                if (!err_reg) begin
                    filter_next = s_raw[2:0];
                    if (s_raw > BYTE_W'(FILTER_PAETH)) begin
                        err_next = 1'b1;
                    end
                end
            end else if (last_in_row) begin
                pos_next = '0;
                if (last_in_image) begin
                    row_pos_next   = '0;
                    first_row_next = 1'b1;
                    err_next       = 1'b0;
                end else begin
                    row_pos_next   = row_pos_reg + ROWPOS_W'(1);
                    first_row_next = 1'b0;
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= CFG_DATA_W'(1);
            bpp_reg       <= BPP_W'(1);
            row_count_reg <= CFG_DATA_W'(1);
            pos_reg       <= '0;
            row_pos_reg   <= '0;
            filter_reg    <= FILTER_NONE;
            first_row_reg <= 1'b1;
            err_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROW_BYTES: row_bytes_reg <= cfg_data;
                    CFG_BPP:       bpp_reg       <= cfg_data[BPP_W-1:0];
                    CFG_ROW_COUNT: row_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            pos_reg       <= pos_next;
            row_pos_reg   <= row_pos_next;
            filter_reg    <= filter_next;
            first_row_reg <= first_row_next;
            err_reg       <= err_next;
        end
    end

endmodule

[design/psu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_queue
// Short queue of ops between the front and the back.
// ----------------------------------------------------------------------------
module psu_queue import psu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = slots_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[design/psu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_back
// Reads the row above from the line store, rebuilds each byte from its
// neighbors and drives the result through the output register.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // from queue
    input  op_t               head_op,
    input  logic              q_empty,
    output logic              q_pop,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_pixel,
    output logic              m_status,
    output logic              m_row_end,
    output logic              m_image_end
);

    logic [BYTE_W-1:0] line_store [MAX_ROW_BYTES];

    op_t               op_reg;
    logic              op_valid_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              fwd_hit_reg;
    logic [BYTE_W-1:0] fwd_data_reg;

    logic [BYTE_W-1:0] left_hist_reg [MAX_BYTES_PER_PIXEL];
    logic [BYTE_W-1:0] up_hist_reg   [MAX_BYTES_PER_PIXEL];

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_pixel_reg;
    logic              out_status_reg;
    logic              out_row_end_reg;
    logic              out_image_end_reg;

    logic              out_free;
    logic              fire;
    logic              wr_en;
    logic [BYTE_W-1:0] nb_a;
    logic [BYTE_W-1:0] nb_b;
    logic [BYTE_W-1:0] nb_c;
    logic [BYTE_W-1:0] above;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W:0]   avg_sum;

    // paeth predictor: pick the neighbor closest to a + b - c
    function automatic logic [BYTE_W-1:0] paeth_pick(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+1:0] da;
        logic signed [BYTE_W+1:0] db;
        logic signed [BYTE_W+1:0] dc;
        logic [BYTE_W+1:0]        pa;
        logic [BYTE_W+1:0]        pb;
        logic [BYTE_W+1:0]        pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? (BYTE_W+2)'(-da) : (BYTE_W+2)'(da);
        pb = (db < 0) ? (BYTE_W+2)'(-db) : (BYTE_W+2)'(db);
        pc = (dc < 0) ? (BYTE_W+2)'(-dc) : (BYTE_W+2)'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    // handshake between queue, compute stage and output register
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = op_valid_reg && out_free;
    assign q_pop    = !q_empty && (!op_valid_reg || fire);
    assign wr_en    = fire && (op_reg.kind == OP_DATA);

    // neighbor selection, with same-cycle write forwarding for the row above
    always_comb begin
        above = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        nb_a  = op_reg.left_ok ? left_hist_reg[op_reg.bpp_sel] : '0;
        nb_b  = op_reg.first_row ? '0 : above;
        nb_c  = (op_reg.left_ok && !op_reg.first_row) ? up_hist_reg[op_reg.bpp_sel] : '0;
    end

    // filter reconstruction
    always_comb begin
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (op_reg.filter)
            FILTER_SUB:   pred = nb_a;
            FILTER_UP:    pred = nb_b;
            FILTER_AVG:   pred = avg_sum[BYTE_W:1];
            FILTER_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
            default:      pred = '0;
        endcase
        value = op_reg.raw + pred;
    end

    // line store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store[op_reg.index] <= value;
        end
        if (q_pop) begin
            rdata_reg <= line_store[head_op.index];
        end
    end

    // compute stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                left_hist_reg[k] <= '0;
                up_hist_reg[k]   <= '0;
            end
        end else begin
            if (q_pop) begin
                op_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (op_reg.index == head_op.index);
            end else if (fire) begin
                op_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                left_hist_reg[0] <= value;
                up_hist_reg[0]   <= nb_b;
                for (int k = 1; k < MAX_BYTES_PER_PIXEL; k++) begin
                    left_hist_reg[k] <= left_hist_reg[k-1];
                    up_hist_reg[k]   <= up_hist_reg[k-1];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg       <= head_op;
            fwd_data_reg <= value;
        end
        if (fire) begin
            if (op_reg.kind == OP_ERROR) begin
                out_pixel_reg     <= '0;
                out_status_reg    <= 1'b1;
                out_row_end_reg   <= 1'b0;
                out_image_end_reg <= 1'b0;
            end else begin
                out_pixel_reg     <= value;
                out_status_reg    <= 1'b0;
                out_row_end_reg   <= op_reg.row_end;
                out_image_end_reg <= op_reg.image_end;
            end
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_pixel     = out_pixel_reg;
    assign m_status    = out_status_reg;
    assign m_row_end   = out_row_end_reg;
    assign m_image_end = out_image_end_reg;

endmodule

[design/png_scanline_unfilter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth).
// ----------------------------------------------------------------------------
// The core takes one byte of the inflated stream per cycle, sustained while
// the result stream is not stalled, and gives one rebuilt byte per data byte;
// a filter type byte gives no word unless its type is invalid, in which case
// one error word comes out and input is dropped until the last row of the
// image has passed. A result passes through the queue, after which the line
// store read for the row above is registered with the op, and then the
// compute stage, which rebuilds the byte from its neighbors and loads the
// output register. The line store does one read and one write per cycle and
// has no clearing pass: the first row of each image treats the row above as
// zero. Configuration is taken at any time and should be written while idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core import psu_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] filtered stream byte
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] pixel_byte
    output logic                   m_tlast,   // row_end
    output logic [1:0]             m_tuser    // [0] status, [1] image_end
);

    op_t  push_op;
    op_t  head_op;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // position tracking and classification
    psu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_raw     (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    // decoupling queue
    psu_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    // reconstruction and output
    psu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_op     (head_op),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_pixel     (m_tdata),
        .m_status    (m_tuser[0]),
        .m_row_end   (m_tlast),
        .m_image_end (m_tuser[1])
    );

endmodule

[design/psu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks on the result stream of the scanline unfilter core.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_core_defines.svh"

module psu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    logic [10:0] m_word;
    logic        err_clean;

    // whole result word, and the shape of an error word
    assign m_word    = {m_tuser, m_tlast, m_tdata};
    assign err_clean = (m_tdata == 8'd0) && !m_tlast && !m_tuser[1];

    // a stalled result holds its value
    `PSU_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

    // an error word carries no pixel and no row or image marker
    `PSU_ASSERT_IMP(a_err_format, aclk, aresetn, m_tvalid && m_tuser[0], err_clean)

    // the image ends only on the last byte of a row
    `PSU_ASSERT_IMP(a_image_end_row, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (.*);
